// ----- design/cau_pkg.sv -----
`default_nettype none

package cau_pkg;

	localparam int CAU_DATA_WIDTH = 32;
	localparam int CAU_FRAC_BITS  = 16;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_MOD  = 3'd4,
		OP_CONJ = 3'd5
	} op_t;

	// per-word control that rides along the pipeline
	typedef struct packed {
		op_t  op;
		logic div_zero;
		logic sat;
		logic neg_re;
		logic neg_im;
	} cau_ctl_t;

endpackage

`default_nettype wire

// ----- design/complex_arithmetic_unit.sv -----
// Complex ALU on signed fixed point (W bits, F fractional, Q16.16 by default).
// Input word on s_*: op, a_re, a_im, b_re, b_im. Result word on m_*:
// res_re, res_im, div_zero, saturated.
// op: add, subtract, multiply, divide, modulus of a, conjugate of a.
// Multiply, divide and modulus round to nearest, ties away from zero; parts out
// of range clip and set saturated. Divide by zero gives zero with div_zero set.
// Throughput: one word per cycle while m_tready does not hold the output. The
// bit-per-stage quotient and square root pipeline (one stage per result bit)
// follows four front stages of operand register, multipliers, cross sums and
// rounding.
// Reset clears all valid bits; payload registers are not reset.
// When m_tready is low with a word on the output, the whole pipeline holds and
// s_tready drops in the same cycle; nothing is lost or repeated.
`default_nettype none

module complex_arithmetic_unit import cau_pkg::*; #(
	parameter int DATA_WIDTH = CAU_DATA_WIDTH,
	parameter int FRAC_BITS  = CAU_FRAC_BITS,
	localparam int IN_BITS   = 3 + 4 * DATA_WIDTH,
	localparam int IN_TDW    = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS  = 2 * DATA_WIDTH + 2,
	localparam int OUT_TDW   = ((OUT_BITS + 7) / 8) * 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [IN_TDW-1:0]  s_tdata,   // op, a_re, a_im, b_re, b_im
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [OUT_TDW-1:0]      m_tdata    // res_re, res_im, div_zero, saturated
);

	localparam int W  = DATA_WIDTH;
	localparam int NW = 2 * W + FRAC_BITS + 2;

	logic                en;
	logic [2:0]          op;
	logic signed [W-1:0] a_re, a_im, b_re, b_im;

	logic             vld_s4;
	cau_ctl_t         ctl_s4;
	logic [W-1:0]     dir_re_s4, dir_im_s4;
	logic [NW-1:0]    num_re_s4, num_im_s4;
	logic [2*W:0]     den2_s4;
	logic [2*W-1:0]   rad_s4;

	logic             it_vld;
	cau_ctl_t         it_ctl;
	logic [W-1:0]     it_dir_re, it_dir_im, it_q_re, it_q_im, it_root;
	logic             it_ovf_re, it_ovf_im;
	logic [2*W:0]     it_root_rem;

	logic [W-1:0]     res_re, res_im;
	logic             div_zero, saturated;

	// whole pipeline advances unless a result is held on the output
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	assign op   = s_tdata[2:0];
	assign a_re = s_tdata[3 + W - 1 : 3];
	assign a_im = s_tdata[3 + 2 * W - 1 : 3 + W];
	assign b_re = s_tdata[3 + 3 * W - 1 : 3 + 2 * W];
	assign b_im = s_tdata[3 + 4 * W - 1 : 3 + 3 * W];

	cau_front #(.W(W), .F(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.op        (op),
		.a_re      (a_re),
		.a_im      (a_im),
		.b_re      (b_re),
		.b_im      (b_im),
		.vld_s4    (vld_s4),
		.ctl_s4    (ctl_s4),
		.dir_re_s4 (dir_re_s4),
		.dir_im_s4 (dir_im_s4),
		.num_re_s4 (num_re_s4),
		.num_im_s4 (num_im_s4),
		.den2_s4   (den2_s4),
		.rad_s4    (rad_s4)
	);

	cau_iter #(.W(W), .F(FRAC_BITS)) u_iter (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.vld_i      (vld_s4),
		.ctl_i      (ctl_s4),
		.dir_re_i   (dir_re_s4),
		.dir_im_i   (dir_im_s4),
		.num_re_i   (num_re_s4),
		.num_im_i   (num_im_s4),
		.den2_i     (den2_s4),
		.rad_i      (rad_s4),
		.vld_o      (it_vld),
		.ctl_o      (it_ctl),
		.dir_re_o   (it_dir_re),
		.dir_im_o   (it_dir_im),
		.q_re_o     (it_q_re),
		.q_im_o     (it_q_im),
		.ovf_re_o   (it_ovf_re),
		.ovf_im_o   (it_ovf_im),
		.root_o     (it_root),
		.root_rem_o (it_root_rem)
	);

	cau_out #(.W(W)) u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.vld_i      (it_vld),
		.ctl_i      (it_ctl),
		.dir_re_i   (it_dir_re),
		.dir_im_i   (it_dir_im),
		.q_re_i     (it_q_re),
		.q_im_i     (it_q_im),
		.ovf_re_i   (it_ovf_re),
		.ovf_im_i   (it_ovf_im),
		.root_i     (it_root),
		.root_rem_i (it_root_rem),
		.m_tvalid   (m_tvalid),
		.res_re     (res_re),
		.res_im     (res_im),
		.div_zero   (div_zero),
		.saturated  (saturated)
	);

	assign m_tdata = OUT_TDW'({saturated, div_zero, res_im, res_re});

endmodule

`default_nettype wire

// ----- design/cau_front.sv -----
`default_nettype none

module cau_front import cau_pkg::*; #(
	parameter int W = CAU_DATA_WIDTH,
	parameter int F = CAU_FRAC_BITS,
	localparam int NW = 2 * W + F + 2
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire logic [2:0]          op,
	input  wire logic signed [W-1:0] a_re,
	input  wire logic signed [W-1:0] a_im,
	input  wire logic signed [W-1:0] b_re,
	input  wire logic signed [W-1:0] b_im,
	output logic                     vld_s4,
	output cau_ctl_t                 ctl_s4,
	output logic [W-1:0]             dir_re_s4,
	output logic [W-1:0]             dir_im_s4,
	output logic [NW-1:0]            num_re_s4,
	output logic [NW-1:0]            num_im_s4,
	output logic [2*W:0]             den2_s4,
	output logic [2*W-1:0]           rad_s4
);

	localparam logic [2*W+1:0] HALF =
		(F > 0) ? ((2 * W + 2)'(1) << ((F > 0) ? F - 1 : 0)) : '0;

	// clip a magnitude with sign to W bits: {sat, value}
	function automatic logic [W:0] sat_mag(input logic [2*W+1:0] m, input logic neg);
		logic [2*W+1:0] lim;
		logic [W-1:0]   lo;
		lim = neg ? ((2 * W + 2)'(1) << (W - 1)) : (((2 * W + 2)'(1) << (W - 1)) - 1'b1);
		lo  = m[W-1:0];
		if (m > lim) begin
			return {1'b1, neg ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}}};
		end
		return {1'b0, neg ? -lo : lo};
	endfunction

	function automatic logic [W:0] sat_simp(input logic [W:0] v);
		if (v[W] != v[W-1]) begin
			return {1'b1, v[W] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}}};
		end
		return {1'b0, v[W-1:0]};
	endfunction

	logic                    vld_s1, vld_s2, vld_s3;
	op_t                     op_s1, op_s2, op_s3;
	logic signed [W-1:0]     are_s1, aim_s1, bre_s1, bim_s1;
	logic signed [2*W-1:0]   p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	logic signed [W:0]       simp_re_s2, simp_im_s2, simp_re_s3, simp_im_s3;
	logic signed [2*W:0]     pre_re_s3, pre_im_s3;
	logic [2*W-1:0]          den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// stage 1: operand registers
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= op_t'(op);
			are_s1 <= a_re;
			aim_s1 <= a_im;
			bre_s1 <= b_re;
			bim_s1 <= b_im;
		end
	end

	// stage 2: products, plus the add/sub/conjugate results
	logic signed [W-1:0] sq_x, sq_y;
	logic signed [W:0]   ea_re, ea_im, eb_re, eb_im, simp_re, simp_im;

	always_comb begin
		sq_x  = (op_s1 == OP_MOD) ? are_s1 : bre_s1;
		sq_y  = (op_s1 == OP_MOD) ? aim_s1 : bim_s1;
		ea_re = {are_s1[W-1], are_s1};
		ea_im = {aim_s1[W-1], aim_s1};
		eb_re = {bre_s1[W-1], bre_s1};
		eb_im = {bim_s1[W-1], bim_s1};
		unique case (op_s1)
			OP_ADD: begin
				simp_re = ea_re + eb_re;
				simp_im = ea_im + eb_im;
			end
			OP_SUB: begin
				simp_re = ea_re - eb_re;
				simp_im = ea_im - eb_im;
			end
			OP_CONJ: begin
				simp_re = ea_re;
				simp_im = -ea_im;
			end
			default: begin
				simp_re = '0;
				simp_im = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2      <= op_s1;
			p0_s2      <= are_s1 * bre_s1;
			p1_s2      <= aim_s1 * bim_s1;
			p2_s2      <= are_s1 * bim_s1;
			p3_s2      <= aim_s1 * bre_s1;
			p4_s2      <= sq_x * sq_x;
			p5_s2      <= sq_y * sq_y;
			simp_re_s2 <= simp_re;
			simp_im_s2 <= simp_im;
		end
	end

	// stage 3: cross sums; divide takes a * conj(b)
	logic signed [2*W:0] e0, e1, e2, e3, pre_re, pre_im;

	always_comb begin
		e0 = {p0_s2[2*W-1], p0_s2};
		e1 = {p1_s2[2*W-1], p1_s2};
		e2 = {p2_s2[2*W-1], p2_s2};
		e3 = {p3_s2[2*W-1], p3_s2};
		unique case (op_s2)
			OP_MUL: begin
				pre_re = e0 - e1;
				pre_im = e2 + e3;
			end
			OP_DIV: begin
				pre_re = e0 + e1;
				pre_im = e3 - e2;
			end
			default: begin
				pre_re = '0;
				pre_im = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s3      <= op_s2;
			pre_re_s3  <= pre_re;
			pre_im_s3  <= pre_im;
			den_s3     <= p4_s2 + p5_s2;
			simp_re_s3 <= simp_re_s2;
			simp_im_s3 <= simp_im_s2;
		end
	end

	// stage 4: magnitudes, rounding of the product, dividend setup
	logic           neg_re, neg_im, sat_re, sat_im;
	logic [2*W:0]   mag_re, mag_im;
	logic [2*W+1:0] rnd_re, rnd_im;
	logic [W-1:0]   dir_re, dir_im;
	cau_ctl_t       ctl;

	always_comb begin
		neg_re = pre_re_s3[2*W];
		neg_im = pre_im_s3[2*W];
		mag_re = neg_re ? -pre_re_s3 : pre_re_s3;
		mag_im = neg_im ? -pre_im_s3 : pre_im_s3;
		rnd_re = ({1'b0, mag_re} + HALF) >> F;
		rnd_im = ({1'b0, mag_im} + HALF) >> F;
		unique case (op_s3)
			OP_MUL: begin
				{sat_re, dir_re} = sat_mag(rnd_re, neg_re);
				{sat_im, dir_im} = sat_mag(rnd_im, neg_im);
			end
			OP_ADD, OP_SUB, OP_CONJ: begin
				{sat_re, dir_re} = sat_simp(simp_re_s3);
				{sat_im, dir_im} = sat_simp(simp_im_s3);
			end
			default: begin
				{sat_re, dir_re} = '0;
				{sat_im, dir_im} = '0;
			end
		endcase
		ctl.op       = op_s3;
		ctl.div_zero = (op_s3 == OP_DIV) && (den_s3 == '0);
		ctl.sat      = sat_re | sat_im;
		ctl.neg_re   = neg_re;
		ctl.neg_im   = neg_im;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s4    <= ctl;
			dir_re_s4 <= dir_re;
			dir_im_s4 <= dir_im;
			num_re_s4 <= (NW'(mag_re) << (F + 1)) + NW'(den_s3);
			num_im_s4 <= (NW'(mag_im) << (F + 1)) + NW'(den_s3);
			den2_s4   <= {den_s3, 1'b0};
			rad_s4    <= den_s3;
		end
	end

endmodule

`default_nettype wire

// ----- design/cau_iter.sv -----
`default_nettype none

// one quotient bit and one root bit per stage, MSB first
module cau_iter import cau_pkg::*; #(
	parameter int W = CAU_DATA_WIDTH,
	parameter int F = CAU_FRAC_BITS,
	localparam int NW = 2 * W + F + 2,
	localparam int RW = (NW > 3 * W + 1) ? NW : 3 * W + 1,
	localparam int SW = 2 * W + 1
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           vld_i,
	input  wire cau_ctl_t       ctl_i,
	input  wire logic [W-1:0]   dir_re_i,
	input  wire logic [W-1:0]   dir_im_i,
	input  wire logic [NW-1:0]  num_re_i,
	input  wire logic [NW-1:0]  num_im_i,
	input  wire logic [2*W:0]   den2_i,
	input  wire logic [2*W-1:0] rad_i,
	output logic                vld_o,
	output cau_ctl_t            ctl_o,
	output logic [W-1:0]        dir_re_o,
	output logic [W-1:0]        dir_im_o,
	output logic [W-1:0]        q_re_o,
	output logic [W-1:0]        q_im_o,
	output logic                ovf_re_o,
	output logic                ovf_im_o,
	output logic [W-1:0]        root_o,
	output logic [SW-1:0]       root_rem_o
);

	logic           vld_s   [0:W];
	cau_ctl_t       ctl_s   [0:W];
	logic [W-1:0]   dre_s   [0:W];
	logic [W-1:0]   dim_s   [0:W];
	logic [RW-1:0]  rre_s   [0:W];
	logic [RW-1:0]  rim_s   [0:W];
	logic [2*W:0]   dd_s    [0:W];
	logic [W-1:0]   qre_s   [0:W];
	logic [W-1:0]   qim_s   [0:W];
	logic           ovre_s  [0:W];
	logic           ovim_s  [0:W];
	logic [W-1:0]   root_s  [0:W];
	logic [SW-1:0]  srem_s  [0:W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_i;
		end
	end

	// stage 0: quotient overflow check, remainders loaded
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s[0]  <= ctl_i;
			dre_s[0]  <= dir_re_i;
			dim_s[0]  <= dir_im_i;
			rre_s[0]  <= RW'(num_re_i);
			rim_s[0]  <= RW'(num_im_i);
			dd_s[0]   <= den2_i;
			ovre_s[0] <= RW'(num_re_i) >= (RW'(den2_i) << W);
			ovim_s[0] <= RW'(num_im_i) >= (RW'(den2_i) << W);
			qre_s[0]  <= '0;
			qim_s[0]  <= '0;
			root_s[0] <= '0;
			srem_s[0] <= SW'(rad_i);
		end
	end

	genvar k;
	generate
		for (k = 1; k <= W; k++) begin : g_step
			localparam int B = W - k;
			localparam logic [W-1:0] BIT = W'(1) << B;

			logic [RW-1:0] dsh;
			logic [SW-1:0] trial;
			logic          take_re, take_im, take_sq;

			assign dsh     = RW'(dd_s[k-1]) << B;
			assign take_re = rre_s[k-1] >= dsh;
			assign take_im = rim_s[k-1] >= dsh;
			// (s + 2^B)^2 - s^2
			assign trial   = (SW'(root_s[k-1]) << (B + 1)) + (SW'(1) << (2 * B));
			assign take_sq = srem_s[k-1] >= trial;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (en) begin
					vld_s[k] <= vld_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					ctl_s[k]  <= ctl_s[k-1];
					dre_s[k]  <= dre_s[k-1];
					dim_s[k]  <= dim_s[k-1];
					dd_s[k]   <= dd_s[k-1];
					ovre_s[k] <= ovre_s[k-1];
					ovim_s[k] <= ovim_s[k-1];
					rre_s[k]  <= take_re ? rre_s[k-1] - dsh : rre_s[k-1];
					rim_s[k]  <= take_im ? rim_s[k-1] - dsh : rim_s[k-1];
					qre_s[k]  <= take_re ? (qre_s[k-1] | BIT) : qre_s[k-1];
					qim_s[k]  <= take_im ? (qim_s[k-1] | BIT) : qim_s[k-1];
					srem_s[k] <= take_sq ? srem_s[k-1] - trial : srem_s[k-1];
					root_s[k] <= take_sq ? (root_s[k-1] | BIT) : root_s[k-1];
				end
			end
		end
	endgenerate

	assign vld_o      = vld_s[W];
	assign ctl_o      = ctl_s[W];
	assign dir_re_o   = dre_s[W];
	assign dir_im_o   = dim_s[W];
	assign q_re_o     = qre_s[W];
	assign q_im_o     = qim_s[W];
	assign ovf_re_o   = ovre_s[W];
	assign ovf_im_o   = ovim_s[W];
	assign root_o     = root_s[W];
	assign root_rem_o = srem_s[W];

endmodule

`default_nettype wire

// ----- design/cau_out.sv -----
`default_nettype none

module cau_out import cau_pkg::*; #(
	parameter int W = CAU_DATA_WIDTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         vld_i,
	input  wire cau_ctl_t     ctl_i,
	input  wire logic [W-1:0] dir_re_i,
	input  wire logic [W-1:0] dir_im_i,
	input  wire logic [W-1:0] q_re_i,
	input  wire logic [W-1:0] q_im_i,
	input  wire logic         ovf_re_i,
	input  wire logic         ovf_im_i,
	input  wire logic [W-1:0] root_i,
	input  wire logic [2*W:0] root_rem_i,
	output logic              m_tvalid,
	output logic [W-1:0]      res_re,
	output logic [W-1:0]      res_im,
	output logic              div_zero,
	output logic              saturated
);

	function automatic logic [W:0] sat_u(input logic [W:0] m, input logic neg);
		logic [W:0]   lim;
		logic [W-1:0] lo;
		lim = neg ? ((W + 1)'(1) << (W - 1)) : (((W + 1)'(1) << (W - 1)) - 1'b1);
		lo  = m[W-1:0];
		if (m > lim) begin
			return {1'b1, neg ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}}};
		end
		return {1'b0, neg ? -lo : lo};
	endfunction

	logic         vld_q, dz_q, sat_q;
	logic [W-1:0] re_q, im_q;
	logic [W:0]   rnd_root;
	logic [W-1:0] re, im;
	logic         sre, sim, dz, sat;

	always_comb begin
		// round to nearest: bump when x - s^2 > s
		rnd_root = {1'b0, root_i} + (W + 1)'(root_rem_i > (2 * W + 1)'(root_i));
		sre = 1'b0;
		sim = 1'b0;
		dz  = 1'b0;
		unique case (ctl_i.op)
			OP_DIV: begin
				if (ctl_i.div_zero) begin
					re = '0;
					im = '0;
					dz = 1'b1;
				end else begin
					{sre, re} = sat_u({ovf_re_i, q_re_i}, ctl_i.neg_re);
					{sim, im} = sat_u({ovf_im_i, q_im_i}, ctl_i.neg_im);
				end
				sat = sre | sim;
			end
			OP_MOD: begin
				{sre, re} = sat_u(rnd_root, 1'b0);
				im  = '0;
				sat = sre;
			end
			default: begin
				re  = dir_re_i;
				im  = dir_im_i;
				sat = ctl_i.sat;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			re_q  <= re;
			im_q  <= im;
			dz_q  <= dz;
			sat_q <= sat;
		end
	end

	assign m_tvalid  = vld_q;
	assign res_re    = re_q;
	assign res_im    = im_q;
	assign div_zero  = dz_q;
	assign saturated = sat_q;

	a_dz_clean: assert property (@(posedge clk) disable iff (!arst_n)
		vld_i && en && ctl_i.div_zero |=> m_tvalid && div_zero && !saturated
			&& res_re == '0 && res_im == '0)
		else $error("divide by zero word not cleared");

	a_mod_real: assert property (@(posedge clk) disable iff (!arst_n)
		vld_i && en && ctl_i.op == OP_MOD |=> res_im == '0 && !res_re[W-1] && !div_zero)
		else $error("modulus word malformed");

	a_dz_only_div: assert property (@(posedge clk) disable iff (!arst_n)
		vld_i && en && ctl_i.op != OP_DIV |=> !div_zero)
		else $error("div_zero outside divide");

endmodule

`default_nettype wire

// ----- verif/complex_arithmetic_unit_test.sv -----
`timescale 1ns / 1ps

module complex_arithmetic_unit_test;
	import cau_pkg::*;

	localparam int W = CAU_DATA_WIDTH;
	localparam int F = CAU_FRAC_BITS;
	localparam int IN_TDW = ((3 + 4 * W + 7) / 8) * 8;
	localparam int OUT_TDW = ((2 * W + 2 + 7) / 8) * 8;
	localparam logic [2:0] OP_RSV6 = 3'd6;
	localparam logic [2:0] OP_RSV7 = 3'd7;
	localparam int N_RANDOM = 1250;
	localparam int QUIET_TAIL = 150;
	localparam int DRAIN_AT = 600;
	localparam int LATENCY = W + 6;
	localparam int STALL_LIMIT = 20 * LATENCY + 500;
	localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] ONE_V = 1 << F;

	typedef struct {
		logic [2:0]   op;
		logic [W-1:0] a_re, a_im, b_re, b_im;
	} cplx_req_t;

	typedef struct {
		logic [W-1:0] re, im;
		logic         dz, sat;
	} cplx_res_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_TDW-1:0]   s_tdata = '0;   // op, a_re, a_im, b_re, b_im
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_TDW-1:0]  m_tdata;        // res_re, res_im, div_zero, saturated

	cplx_req_t req_queue[$];
	cplx_res_t expected_res[$];
	cplx_req_t cur_req;
	int        n_items;
	int        sent_cnt = 0;
	int        fail_cnt = 0;
	int        src_gap = 0;
	int        snk_gap = 0;
	int        idle_cycles = 0;

	complex_arithmetic_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic signed [127:0] widen(logic [W-1:0] v);
		return {{(128-W){v[W-1]}}, v};
	endfunction

	function automatic logic [127:0] magnitude(logic signed [127:0] x);
		return x < 0 ? -x : x;
	endfunction

	// round to nearest, ties away from zero, dropping F fraction bits
	function automatic logic [127:0] round_mag(logic signed [127:0] x);
		return (magnitude(x) + (128'd1 << (F - 1))) >> F;
	endfunction

	function automatic logic [W-1:0] clip(logic neg, logic [127:0] mag, inout logic sat);
		logic [127:0] lim;
		lim = neg ? (128'd1 << (W - 1)) : (128'd1 << (W - 1)) - 1;
		if (mag > lim) begin
			sat = 1'b1;
			mag = lim;
		end
		return neg ? W'(-mag) : W'(mag);
	endfunction

	function automatic logic [127:0] sqrt_nearest(logic [127:0] x);
		logic [127:0] s, t;
		s = '0;
		for (int i = W; i >= 0; i--) begin
			t = s | (128'd1 << i);
			if (t * t <= x)
				s = t;
		end
		if (x - s * s > s)
			s = s + 1;
		return s;
	endfunction

	function automatic cplx_res_t complex_result(cplx_req_t r);
		cplx_res_t o;
		logic signed [127:0] ar, ai, br, bi, xr, xi, den;
		logic sat;
		ar = widen(r.a_re);
		ai = widen(r.a_im);
		br = widen(r.b_re);
		bi = widen(r.b_im);
		sat = 1'b0;
		o.dz = 1'b0;
		o.re = '0;
		o.im = '0;
		case (r.op)
			OP_ADD, OP_SUB, OP_CONJ: begin
				if (r.op == OP_ADD) begin
					xr = ar + br;
					xi = ai + bi;
				end else if (r.op == OP_SUB) begin
					xr = ar - br;
					xi = ai - bi;
				end else begin
					xr = ar;
					xi = -ai;
				end
				o.re = clip(xr < 0, magnitude(xr), sat);
				o.im = clip(xi < 0, magnitude(xi), sat);
			end
			OP_MUL: begin
				xr = ar * br - ai * bi;
				xi = ar * bi + ai * br;
				o.re = clip(xr < 0, round_mag(xr), sat);
				o.im = clip(xi < 0, round_mag(xi), sat);
			end
			OP_DIV: begin
				den = br * br + bi * bi;
				if (den == 0)
					o.dz = 1'b1;
				else begin
					xr = ar * br + ai * bi;
					xi = ai * br - ar * bi;
					o.re = clip(xr < 0,
						((magnitude(xr) << (F + 1)) + den) / (den << 1), sat);
					o.im = clip(xi < 0,
						((magnitude(xi) << (F + 1)) + den) / (den << 1), sat);
				end
			end
			OP_MOD: o.re = clip(1'b0, sqrt_nearest(ar * ar + ai * ai), sat);
			default: ;
		endcase
		o.sat = sat;
		return o;
	endfunction

	function automatic logic [W-1:0] rand_operand();
		case ($urandom_range(0, 5))
			0, 1: return W'($urandom);
			2: return W'($urandom_range(0, 1 << 21)) - W'(1 << 20);
			3: begin
				case ($urandom_range(0, 5))
					0: return MIN_V;
					1: return MAX_V;
					2: return '0;
					3: return '1;
					4: return ONE_V;
					default: return -ONE_V;
				endcase
			end
			default: return W'($signed($urandom) >>> $urandom_range(0, 24));
		endcase
	endfunction

	function automatic cplx_req_t make_req(logic [2:0] op, logic [W-1:0] a_re,
		logic [W-1:0] a_im, logic [W-1:0] b_re, logic [W-1:0] b_im);
		cplx_req_t r;
		r.op = op;
		r.a_re = a_re;
		r.a_im = a_im;
		r.b_re = b_re;
		r.b_im = b_im;
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			src_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_res.push_back(complex_result(cur_req));
				sent_cnt++;
			end
			if (!(s_tvalid && !s_tready)) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					s_tvalid <= 1'b0;
				end else if (sent_cnt == DRAIN_AT && expected_res.size() != 0) begin
					s_tvalid <= 1'b0;
				end else if (req_queue.size() != 0) begin
					cur_req = req_queue.pop_front();
					s_tdata <= IN_TDW'({cur_req.b_im, cur_req.b_re, cur_req.a_im,
						cur_req.a_re, cur_req.op});
					s_tvalid <= 1'b1;
					if (sent_cnt < n_items - QUIET_TAIL && $urandom_range(0, 7) == 0)
						src_gap <= $urandom_range(1, 11);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor and scoreboard
	always @(posedge clk or negedge arst_n) begin
		cplx_res_t exp_w;
		logic [W-1:0] got_re, got_im;
		logic got_dz, got_sat;
		if (!arst_n) begin
			m_tready <= 1'b0;
			snk_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_re = m_tdata[W-1:0];
				got_im = m_tdata[2*W-1:W];
				got_dz = m_tdata[2*W];
				got_sat = m_tdata[2*W+1];
				if (expected_res.size() == 0) begin
					$error("unexpected result word: %h", m_tdata);
					fail_cnt++;
				end else begin
					exp_w = expected_res.pop_front();
					if (got_re !== exp_w.re) begin
						$error("res_re: expected %h, got %h", exp_w.re, got_re);
						fail_cnt++;
					end
					if (got_im !== exp_w.im) begin
						$error("res_im: expected %h, got %h", exp_w.im, got_im);
						fail_cnt++;
					end
					if (got_dz !== exp_w.dz) begin
						$error("div_zero: expected %b, got %b", exp_w.dz, got_dz);
						fail_cnt++;
					end
					if (got_sat !== exp_w.sat) begin
						$error("saturated: expected %b, got %b", exp_w.sat, got_sat);
						fail_cnt++;
					end
				end
			end
			if (snk_gap > 0) begin
				snk_gap <= snk_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (sent_cnt < n_items - QUIET_TAIL && $urandom_range(0, 7) == 0)
					snk_gap <= $urandom_range(1, 11);
			end
		end
	end

	// watchdog: cycles with no word moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("complex_arithmetic_unit test failed");
			$finish;
		end
	end

	initial begin
		logic [2:0] op;
		cplx_req_t r;
		// directed: extremes, every op, rounding ties, zero divisor, unused codes
		req_queue.push_back(make_req(OP_ADD, MAX_V, MIN_V, ONE_V, -ONE_V));
		req_queue.push_back(make_req(OP_ADD, MIN_V, MAX_V, '1, 1));
		req_queue.push_back(make_req(OP_SUB, MIN_V, MAX_V, 1, '1));
		req_queue.push_back(make_req(OP_SUB, ONE_V, 0, ONE_V, 0));
		req_queue.push_back(make_req(OP_MUL, MAX_V, MIN_V, MAX_V, MIN_V));
		req_queue.push_back(make_req(OP_MUL, MIN_V, MIN_V, MIN_V, MIN_V));
		req_queue.push_back(make_req(OP_MUL, 1, '1, W'(1 << (F - 1)), 0));
		req_queue.push_back(make_req(OP_MUL, ONE_V, ONE_V, ONE_V, -ONE_V));
		req_queue.push_back(make_req(OP_DIV, ONE_V, 0, 0, 0));
		req_queue.push_back(make_req(OP_DIV, MAX_V, MIN_V, 1, 0));
		req_queue.push_back(make_req(OP_DIV, MIN_V, MIN_V, MIN_V, MIN_V));
		req_queue.push_back(make_req(OP_DIV, ONE_V, 0, 3 * ONE_V, 0));
		req_queue.push_back(make_req(OP_DIV, 1, 0, MAX_V, MAX_V));
		req_queue.push_back(make_req(OP_MOD, MIN_V, MIN_V, 0, 0));
		req_queue.push_back(make_req(OP_MOD, 3 * ONE_V, -(4 * ONE_V), MAX_V, MIN_V));
		req_queue.push_back(make_req(OP_MOD, 1, 1, 0, 0));
		req_queue.push_back(make_req(OP_CONJ, MAX_V, MIN_V, 0, 0));
		req_queue.push_back(make_req(OP_CONJ, MIN_V, MAX_V, 0, 0));
		req_queue.push_back(make_req(OP_RSV6, MAX_V, MAX_V, MAX_V, MAX_V));
		req_queue.push_back(make_req(OP_RSV7, MIN_V, MIN_V, MIN_V, MIN_V));
		for (int i = 0; i < N_RANDOM; i++) begin
			op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(0, 5));
			r = make_req(op, rand_operand(), rand_operand(), rand_operand(),
				rand_operand());
			if (op == OP_DIV && $urandom_range(0, 15) == 0) begin
				r.b_re = '0;
				r.b_im = '0;
			end
			req_queue.push_back(r);
		end
		n_items = req_queue.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		while (req_queue.size() != 0 || s_tvalid || expected_res.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (fail_cnt == 0)
			$display("complex_arithmetic_unit test passed");
		else
			$display("complex_arithmetic_unit test failed");
		$finish;
	end

endmodule

// ----- files.f -----
design/cau_pkg.sv
design/cau_front.sv
design/cau_iter.sv
design/cau_out.sv
design/complex_arithmetic_unit.sv
verif/complex_arithmetic_unit_test.sv
